/* rtl/sactc_pkg.sv */
`timescale 1ns / 1ps
package sactc_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int TAG_BITS    = 20;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int WAYS_W      = IDX_W + 1;
  localparam int DIV_W       = 16;
  localparam int CNT_W       = 32;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] PLACE_DIRECT = 2'd0;
  localparam logic [1:0] PLACE_FULL   = 2'd1;
  localparam logic [1:0] PLACE_NWAY   = 2'd2;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;

  localparam logic [1:0] CFG_PLACEMENT = 2'd0;
  localparam logic [1:0] CFG_POLICY    = 2'd1;
  localparam logic [1:0] CFG_WAYS      = 2'd2;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  set_index;
    logic [19:0] tag_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  way_used;
    logic [31:0] read_hit_count;
    logic [31:0] read_miss_count;
    logic [31:0] write_hit_count;
    logic [31:0] write_miss_count;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVS, S_WAITS, S_DIVI, S_WAITI, S_BASE, S_SCAN_RD, S_SCAN_CMP,
    S_DECIDE, S_RND, S_RND_WAIT, S_FIFO_RD, S_FIFO_UPD, S_TOUCH_RD, S_TOUCH_WR,
    S_FILL, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_stats;
    logic go_sets;
    logic go_set;
    logic go_rnd;
    logic take_sets;
    logic take_set;
    logic take_rnd;
    logic calc_base;
    logic mem_rd;
    logic scan_cmp;
    logic cnt_clr;
    logic cnt_inc;
    logic decide;
    logic lfsr_step;
    logic fifo_rd;
    logic fifo_upd;
    logic touch_wr;
    logic fill;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic cnt_last;
    logic found;
    logic pol_rnd;
    logic pol_fifo;
  } sts_t;

endpackage

/* rtl/sactc_div.sv */
`timescale 1ns / 1ps
module sactc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sactc_pkg::DIV_W-1:0]      dividend,
  input  logic [sactc_pkg::WAYS_W-1:0]     divisor,
  output logic                             done,
  output logic [sactc_pkg::DIV_W-1:0]      quotient,
  output logic [sactc_pkg::WAYS_W-1:0]     remainder
);

  logic                                 running;
  logic [$clog2(sactc_pkg::DIV_W)-1:0]  step;
  logic [sactc_pkg::DIV_W-1:0]          num;
  logic [sactc_pkg::WAYS_W-1:0]         rem;
  logic [sactc_pkg::WAYS_W-1:0]         den;
  logic [sactc_pkg::WAYS_W:0]           trial;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, num[sactc_pkg::DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == $clog2(sactc_pkg::DIV_W)'(sactc_pkg::DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (running) begin
      if (trial >= {1'b0, den}) begin
        rem <= sactc_pkg::WAYS_W'(trial - {1'b0, den});
        num <= {num[sactc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[sactc_pkg::WAYS_W-1:0];
        num <= {num[sactc_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = num;
  assign remainder = rem;

endmodule

/* rtl/sactc_ctrl.sv */
`timescale 1ns / 1ps
module sactc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           command,
  input  sactc_pkg::sts_t      sts,
  output sactc_pkg::ctl_t      ctl,
  output logic                 busy,
  output logic                 done
);

  sactc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sactc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    done       = 1'b0;
    case (state)
      sactc_pkg::S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          if (command == sactc_pkg::CMD_READ || command == sactc_pkg::CMD_WRITE) begin
            state_next = sactc_pkg::S_DIVS;
          end else begin
            ctl.clr_stats = (command == sactc_pkg::CMD_CLEAR);
            state_next    = sactc_pkg::S_OUT;
          end
        end
      end
      sactc_pkg::S_DIVS: begin
        ctl.go_sets = 1'b1;
        state_next  = sactc_pkg::S_WAITS;
      end
      sactc_pkg::S_WAITS: begin
        if (sts.div_done) begin
          ctl.take_sets = 1'b1;
          state_next    = sactc_pkg::S_DIVI;
        end
      end
      sactc_pkg::S_DIVI: begin
        ctl.go_set = 1'b1;
        state_next = sactc_pkg::S_WAITI;
      end
      sactc_pkg::S_WAITI: begin
        if (sts.div_done) begin
          ctl.take_set = 1'b1;
          state_next   = sactc_pkg::S_BASE;
        end
      end
      sactc_pkg::S_BASE: begin
        ctl.calc_base = 1'b1;
        state_next    = sactc_pkg::S_SCAN_RD;
      end
      sactc_pkg::S_SCAN_RD: begin
        ctl.mem_rd = 1'b1;
        state_next = sactc_pkg::S_SCAN_CMP;
      end
      sactc_pkg::S_SCAN_CMP: begin
        ctl.scan_cmp = 1'b1;
        if (sts.cnt_last) begin
          state_next = sactc_pkg::S_DECIDE;
        end else begin
          ctl.cnt_inc = 1'b1;
          state_next  = sactc_pkg::S_SCAN_RD;
        end
      end
      sactc_pkg::S_DECIDE: begin
        ctl.decide  = 1'b1;
        ctl.cnt_clr = 1'b1;
        if (sts.found) begin
          state_next = (sts.pol_rnd || sts.pol_fifo) ? sactc_pkg::S_OUT
                                                     : sactc_pkg::S_TOUCH_RD;
        end else if (sts.pol_rnd) begin
          ctl.lfsr_step = 1'b1;
          state_next    = sactc_pkg::S_RND;
        end else if (sts.pol_fifo) begin
          state_next = sactc_pkg::S_FIFO_RD;
        end else begin
          state_next = sactc_pkg::S_TOUCH_RD;
        end
      end
      sactc_pkg::S_RND: begin
        ctl.go_rnd = 1'b1;
        state_next = sactc_pkg::S_RND_WAIT;
      end
      sactc_pkg::S_RND_WAIT: begin
        if (sts.div_done) begin
          ctl.take_rnd = 1'b1;
          state_next   = sactc_pkg::S_FILL;
        end
      end
      sactc_pkg::S_FIFO_RD: begin
        ctl.fifo_rd = 1'b1;
        state_next  = sactc_pkg::S_FIFO_UPD;
      end
      sactc_pkg::S_FIFO_UPD: begin
        ctl.fifo_upd = 1'b1;
        state_next   = sactc_pkg::S_FILL;
      end
      sactc_pkg::S_TOUCH_RD: begin
        ctl.mem_rd = 1'b1;
        state_next = sactc_pkg::S_TOUCH_WR;
      end
      sactc_pkg::S_TOUCH_WR: begin
        ctl.touch_wr = 1'b1;
        if (sts.cnt_last) begin
          state_next = sts.found ? sactc_pkg::S_OUT : sactc_pkg::S_FILL;
        end else begin
          ctl.cnt_inc = 1'b1;
          state_next  = sactc_pkg::S_TOUCH_RD;
        end
      end
      sactc_pkg::S_FILL: begin
        ctl.fill   = 1'b1;
        state_next = sactc_pkg::S_OUT;
      end
      sactc_pkg::S_OUT: begin
        done       = 1'b1;
        state_next = sactc_pkg::S_IDLE;
      end
      default: begin
        state_next = sactc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != sactc_pkg::S_IDLE);

endmodule

/* rtl/sactc_datapath.sv */
`timescale 1ns / 1ps
module sactc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sactc_pkg::req_t      req,
  input  sactc_pkg::ctl_t      ctl,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data,
  output sactc_pkg::sts_t      sts,
  output sactc_pkg::res_t      result
);

  localparam int IW = sactc_pkg::IDX_W;
  localparam int WW = sactc_pkg::WAYS_W;

  // Configuration.
  logic [1:0]    place;
  logic [1:0]    pol;
  logic [6:0]    ways_cfg;
  logic          flush;

  // Access state.
  sactc_pkg::req_t                 req_q;
  logic [WW-1:0]                   sets_q;
  logic [IW-1:0]                   set_q;
  logic [IW-1:0]                   base;
  logic [IW-1:0]                   cnt;
  logic                            found;
  logic [IW-1:0]                   hit_way;
  logic [IW-1:0]                   hit_rank;
  logic [IW-1:0]                   best;
  logic [IW-1:0]                   max_way;
  logic [IW-1:0]                   way;
  logic [IW-1:0]                   old_rank;
  logic [15:0]                     lfsr;
  logic [sactc_pkg::CNT_W-1:0]     stat [4];

  // Memories and their read registers.
  logic [sactc_pkg::TAG_BITS-1:0]  tag_mem  [sactc_pkg::NUM_ENTRIES];
  logic [IW-1:0]                   rank_mem [sactc_pkg::NUM_ENTRIES];
  logic [IW-1:0]                   fifo_mem [sactc_pkg::NUM_ENTRIES];
  logic [sactc_pkg::NUM_ENTRIES-1:0] valid;
  logic [sactc_pkg::NUM_ENTRIES-1:0] rinit;
  logic [sactc_pkg::NUM_ENTRIES-1:0] finit;
  logic [sactc_pkg::TAG_BITS-1:0]  tag_q;
  logic [IW-1:0]                   rank_q;
  logic                            valid_q;
  logic                            rinit_q;
  logic [IW-1:0]                   fptr_q;
  logic                            finit_q;

  // Combinational helpers.
  logic [WW-1:0]                   w;
  logic [IW-1:0]                   w_last;
  logic [IW-1:0]                   addr;
  logic [IW-1:0]                   fill_addr;
  logic [IW-1:0]                   rank_eff;
  logic [IW-1:0]                   rank_new;
  logic [IW-1:0]                   fptr_eff;
  logic [1:0]                      bump_idx;
  logic                            div_go;
  logic [sactc_pkg::DIV_W-1:0]     div_num;
  logic [WW-1:0]                   div_den;
  logic                            div_done;
  logic [sactc_pkg::DIV_W-1:0]     div_q;
  logic [WW-1:0]                   div_r;

  always_comb begin
    case (place)
      sactc_pkg::PLACE_DIRECT: w = WW'(1);
      sactc_pkg::PLACE_FULL:   w = WW'(sactc_pkg::NUM_ENTRIES);
      default: begin
        if (ways_cfg == '0) begin
          w = WW'(1);
        end else if (ways_cfg > 7'(sactc_pkg::NUM_ENTRIES)) begin
          w = WW'(sactc_pkg::NUM_ENTRIES);
        end else begin
          w = WW'(ways_cfg);
        end
      end
    endcase
  end

  assign w_last    = IW'(w - 1'b1);
  assign addr      = IW'(base + cnt);
  assign fill_addr = IW'(base + way);
  assign rank_eff  = rinit_q ? rank_q : w_last;
  assign fptr_eff  = finit_q ? fptr_q : '0;
  assign bump_idx  = {req_q.command == sactc_pkg::CMD_WRITE, ~found};

  always_comb begin
    if (cnt == way) begin
      rank_new = '0;
    end else if (rank_eff < old_rank) begin
      rank_new = IW'(rank_eff + 1'b1);
    end else begin
      rank_new = rank_eff;
    end
  end

  // Shared divider: number of sets, set reduction and random victim.
  assign div_go = ctl.go_sets | ctl.go_set | ctl.go_rnd;

  always_comb begin
    if (ctl.go_sets) begin
      div_num = sactc_pkg::DIV_W'(sactc_pkg::NUM_ENTRIES);
      div_den = w;
    end else if (ctl.go_set) begin
      div_num = sactc_pkg::DIV_W'(req_q.set_index);
      div_den = sets_q;
    end else begin
      div_num = lfsr;
      div_den = w;
    end
  end

  sactc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_go),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign flush = cfg_we && (cfg_index == sactc_pkg::CFG_PLACEMENT ||
                            cfg_index == sactc_pkg::CFG_WAYS);

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      place    <= sactc_pkg::PLACE_NWAY;
      pol      <= sactc_pkg::POL_LRU;
      ways_cfg <= 7'd4;
      lfsr     <= sactc_pkg::LFSR_SEED;
      valid    <= '0;
      rinit    <= '0;
      finit    <= '0;
      for (int i = 0; i < 4; i++) begin
        stat[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sactc_pkg::CFG_PLACEMENT: place    <= cfg_data[1:0];
          sactc_pkg::CFG_POLICY:    pol      <= cfg_data[1:0];
          sactc_pkg::CFG_WAYS:      ways_cfg <= cfg_data;
          default: ;
        endcase
      end
      if (flush) begin
        valid <= '0;
        rinit <= '0;
        finit <= '0;
      end
      if (ctl.lfsr_step) begin
        lfsr <= {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
      end
      if (ctl.clr_stats) begin
        for (int i = 0; i < 4; i++) begin
          stat[i] <= '0;
        end
      end else if (ctl.decide && stat[bump_idx] != '1) begin
        stat[bump_idx] <= stat[bump_idx] + 1'b1;
      end
      if (ctl.touch_wr) begin
        rinit[addr] <= 1'b1;
      end
      if (ctl.fifo_upd) begin
        finit[set_q] <= 1'b1;
      end
      if (ctl.fill) begin
        valid[fill_addr] <= 1'b1;
      end
    end
  end

  // Access registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= req;
      found <= 1'b0;
      way   <= '0;
    end
    if (ctl.take_sets) begin
      sets_q <= div_q[WW-1:0];
    end
    if (ctl.take_set) begin
      set_q <= div_r[IW-1:0];
    end
    if (ctl.calc_base) begin
      base    <= IW'(set_q * w);
      cnt     <= '0;
      best    <= '0;
      max_way <= '0;
    end else if (ctl.cnt_clr) begin
      cnt <= '0;
    end else if (ctl.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
    if (ctl.scan_cmp) begin
      if (!found && valid_q && tag_q == req_q.tag_value) begin
        found    <= 1'b1;
        hit_way  <= cnt;
        hit_rank <= rank_eff;
      end
      if (rank_eff > best) begin
        best    <= rank_eff;
        max_way <= cnt;
      end
    end
    if (ctl.decide) begin
      if (found) begin
        way      <= hit_way;
        old_rank <= hit_rank;
      end else begin
        way      <= max_way;
        old_rank <= best;
      end
    end
    if (ctl.take_rnd) begin
      way <= div_r[IW-1:0];
    end
    // The stored pointer is always below the way count, so it is the victim.
    if (ctl.fifo_upd) begin
      way <= fptr_eff;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      tag_q   <= tag_mem[addr];
      rank_q  <= rank_mem[addr];
      valid_q <= valid[addr];
      rinit_q <= rinit[addr];
    end
    if (ctl.fill) begin
      tag_mem[fill_addr] <= req_q.tag_value;
    end
    if (ctl.touch_wr) begin
      rank_mem[addr] <= rank_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fifo_rd) begin
      fptr_q  <= fifo_mem[set_q];
      finit_q <= finit[set_q];
    end
    if (ctl.fifo_upd) begin
      fifo_mem[set_q] <= (fptr_eff == w_last) ? '0 : IW'(fptr_eff + 1'b1);
    end
  end

  assign sts.div_done = div_done;
  assign sts.cnt_last = (cnt == w_last);
  assign sts.found    = found;
  assign sts.pol_rnd  = (pol == sactc_pkg::POL_RANDOM);
  assign sts.pol_fifo = (pol == sactc_pkg::POL_FIFO);

  assign result.hit              = found;
  assign result.way_used         = way;
  assign result.read_hit_count   = stat[0];
  assign result.read_miss_count  = stat[1];
  assign result.write_hit_count  = stat[2];
  assign result.write_miss_count = stat[3];

endmodule

/* rtl/set_assoc_cache_tag_controller_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// request   start, busy         req    (sactc_pkg::req_t)
// result    done (one cycle)    result (sactc_pkg::res_t)
// config    cfg_we              cfg_index, cfg_data
//
// A read or write hit under random or FIFO passes through two runs of the shared
// 16-step divider (set count, set reduction), then a read and compare per way of
// the set. LRU adds a rank read and write per way; a miss adds a fill, a FIFO victim
// a pointer read and update, and a random victim another divider run. Clear and
// unused commands go straight to the result. Synchronous reset leaves the cache empty.
// The receiver cannot stall: result is valid only in the cycle done is high; a new
// request can be taken the cycle after.
module set_assoc_cache_tag_controller_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sactc_pkg::req_t      req,
  output logic                 done,
  output sactc_pkg::res_t      result,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data
);

  sactc_pkg::ctl_t ctl;
  sactc_pkg::sts_t sts;

  sactc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (req.command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  sactc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .result    (result)
  );

endmodule

/* rtl/sactc_checker.sv */
`timescale 1ns / 1ps
module sactc_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input sactc_pkg::res_t result
);

  // An accepted transfer makes the block busy until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside an access");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block did not return to idle after a result");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> $past(busy))
    else $error("hit reported without a lookup");

endmodule

bind set_assoc_cache_tag_controller_core sactc_checker u_sactc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import sactc_pkg::*;

  localparam int TIMEOUT_CYCLES = 1500000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  res_t result;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  set_assoc_cache_tag_controller_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the cache state.
  logic [1:0]  place_q;
  logic [1:0]  policy_q;
  logic [6:0]  ways_q;
  logic [19:0] tag_mem [NUM_ENTRIES];
  bit          valid_mem [NUM_ENTRIES];
  int          rank_mem [NUM_ENTRIES];
  int          fifo_ptr [NUM_ENTRIES];
  logic [15:0] lfsr_q;
  logic [31:0] stats [4];

  req_t access_queue [$];
  res_t lookup_queue [$];
  int   n_queued;
  int   n_checked;
  int   n_errors;
  int   n_hits;
  int   cycle_count;
  int   gap_left;

  function automatic int active_ways();
    int w;
    if (place_q == PLACE_DIRECT) w = 1;
    else if (place_q == PLACE_FULL) w = NUM_ENTRIES;
    else w = ways_q;
    if (w == 0) w = 1;
    if (w > NUM_ENTRIES) w = NUM_ENTRIES;
    return w;
  endfunction

  function automatic void flush_cache();
    int w;
    w = active_ways();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 0;
      rank_mem[i] = w - 1;
      fifo_ptr[i] = 0;
    end
  endfunction

  function automatic void bump_stat(int k);
    if (stats[k] != 32'hFFFF_FFFF) stats[k] = stats[k] + 1;
  endfunction

  function automatic void promote_way(int base, int w, int way);
    int old;
    old = rank_mem[base + way];
    for (int i = 0; i < w; i++)
      if (i != way && rank_mem[base + i] < old) rank_mem[base + i]++;
    rank_mem[base + way] = 0;
  endfunction

  function automatic res_t lookup_access(req_t r);
    res_t o;
    int w, set, base, way, best;
    bit found;
    logic fb;
    way = 0;
    found = 0;
    if (r.command == CMD_CLEAR) begin
      for (int k = 0; k < 4; k++) stats[k] = '0;
    end else if (r.command == CMD_READ || r.command == CMD_WRITE) begin
      w = active_ways();
      set = int'(r.set_index) % (NUM_ENTRIES / w);
      base = set * w;
      for (int i = 0; i < w; i++) begin
        if (!found && valid_mem[base + i] && tag_mem[base + i] == r.tag_value) begin
          found = 1;
          way = i;
        end
      end
      if (found) begin
        if (policy_q != POL_RANDOM && policy_q != POL_FIFO) promote_way(base, w, way);
        bump_stat(r.command == CMD_READ ? 0 : 2);
      end else begin
        bump_stat(r.command == CMD_READ ? 1 : 3);
        if (policy_q == POL_RANDOM) begin
          fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
          lfsr_q = {fb, lfsr_q[15:1]};
          way = int'(lfsr_q) % w;
        end else if (policy_q == POL_FIFO) begin
          way = fifo_ptr[set] % w;
          fifo_ptr[set] = (way + 1) % w;
        end else begin
          best = 0;
          for (int i = 0; i < w; i++)
            if (rank_mem[base + i] > best) begin
              best = rank_mem[base + i];
              way = i;
            end
          promote_way(base, w, way);
        end
        tag_mem[base + way] = r.tag_value;
        valid_mem[base + way] = 1;
      end
    end
    o.hit = found;
    o.way_used = 6'(way);
    o.read_hit_count = stats[0];
    o.read_miss_count = stats[1];
    o.write_hit_count = stats[2];
    o.write_miss_count = stats[3];
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: one transfer per access, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      req <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        lookup_queue.insert(lookup_queue.size(), lookup_access(req));
        start <= 0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 2);
      end else if (!start) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (access_queue.size() > 0) begin
          req <= access_queue.pop_front();
          start <= 1;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every done cycle is checked.
  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (lookup_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        n_errors++;
      end else begin
        want = lookup_queue.pop_front();
        if (result.hit !== want.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, want.hit, result.hit);
          n_errors++;
        end
        if (result.way_used !== want.way_used) begin
          $display("%0t: way_used exp %0d got %0d", $time, want.way_used,
                   result.way_used);
          n_errors++;
        end
        if (result.read_hit_count !== want.read_hit_count) begin
          $display("%0t: read_hit_count exp %0d got %0d", $time,
                   want.read_hit_count, result.read_hit_count);
          n_errors++;
        end
        if (result.read_miss_count !== want.read_miss_count) begin
          $display("%0t: read_miss_count exp %0d got %0d", $time,
                   want.read_miss_count, result.read_miss_count);
          n_errors++;
        end
        if (result.write_hit_count !== want.write_hit_count) begin
          $display("%0t: write_hit_count exp %0d got %0d", $time,
                   want.write_hit_count, result.write_hit_count);
          n_errors++;
        end
        if (result.write_miss_count !== want.write_miss_count) begin
          $display("%0t: write_miss_count exp %0d got %0d", $time,
                   want.write_miss_count, result.write_miss_count);
          n_errors++;
        end
        if (want.hit) n_hits++;
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_PLACEMENT) begin
      place_q = val[1:0];
      flush_cache();
    end else if (idx == CFG_POLICY) begin
      policy_q = val[1:0];
    end else if (idx == CFG_WAYS) begin
      ways_q = val;
      flush_cache();
    end
  endtask

  task automatic queue_access(logic [1:0] cmd, logic [5:0] set, logic [19:0] tag);
    req_t r;
    r.command = cmd;
    r.set_index = set;
    r.tag_value = tag;
    access_queue.insert(access_queue.size(), r);
    n_queued++;
  endtask

  // Blocks until every queued access has produced its result.
  task automatic drain();
    while (n_checked != n_queued) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [19:0] pool [8];
    logic [1:0] cmd;
    int pick;
    int place_list [10] = '{2, 0, 1, 2, 3, 2, 2, 1, 2, 0};
    int pol_list [10]   = '{0, 1, 2, 3, 1, 2, 0, 0, 2, 2};
    int ways_list [10]  = '{1, 4, 4, 3, 2, 64, 0, 64, 127, 8};

    rst = 1;
    start = 0;
    req = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    n_queued = 0;
    n_checked = 0;
    n_errors = 0;
    n_hits = 0;
    place_q = PLACE_NWAY;
    policy_q = POL_LRU;
    ways_q = 7'd4;
    lfsr_q = LFSR_SEED;
    for (int k = 0; k < 4; k++) stats[k] = '0;
    flush_cache();
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed part under the reset configuration.
    queue_access(CMD_READ, 6'd0, 20'h0);
    queue_access(CMD_READ, 6'd0, 20'h0);
    queue_access(CMD_WRITE, 6'd63, 20'hFFFFF);
    queue_access(CMD_WRITE, 6'd63, 20'hFFFFF);
    queue_access(CMD_READ, 6'd63, 20'hFFFFF);
    for (int i = 1; i <= 5; i++) queue_access(CMD_WRITE, 6'd5, 20'(i));
    queue_access(CMD_READ, 6'd5, 20'd2);
    queue_access(CMD_READ, 6'd5, 20'd1);
    queue_access(2'd3, 6'h2A, 20'h55555);
    queue_access(CMD_CLEAR, 6'h15, 20'hAAAAA);
    queue_access(CMD_READ, 6'd21, 20'hAAAAA);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_POLICY, 7'(pol_list[ph]));
      write_reg(CFG_PLACEMENT, 7'(place_list[ph]));
      write_reg(CFG_WAYS, 7'(ways_list[ph]));
      for (int k = 0; k < 8; k++) pool[k] = 20'($urandom);
      for (int n = 0; n < 40; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) cmd = CMD_CLEAR;
        else if (pick < 5) cmd = 2'd3;
        else cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        // A small pool of tags and sets makes hits and evictions common.
        if ($urandom_range(0, 4) == 0)
          queue_access(cmd, 6'($urandom), 20'($urandom));
        else
          queue_access(cmd, 6'($urandom_range(0, 3)), pool[$urandom_range(0, 7)]);
      end
      if (ph == 4) begin
        // A policy change alone must not flush the cache.
        drain();
        write_reg(CFG_POLICY, 7'd1);
        for (int n = 0; n < 10; n++)
          queue_access(CMD_READ, 6'($urandom_range(0, 3)), pool[$urandom_range(0, 7)]);
      end
      drain();
    end

    $display("Covered %0d accesses (%0d hits) over 11 cache configurations,", n_queued,
             n_hits);
    $display("including all placement, policy and out-of-range way settings.");
    if (n_errors == 0 && lookup_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
